### design/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cfb_pkg.sv
package cfb_pkg;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned RemW       = $clog2(MaxPayload + 1);
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] SeedReset  = 16'hFFFF;
  localparam logic [15:0] SyncReset  = 16'hAA55;
  localparam logic [15:0] TrlReset   = 16'h55AA;

  typedef enum logic {
    OP_HEADER  = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_CRC_SEED = 2'd0,
    CFG_SYNC     = 2'd1,
    CFG_TRAILER  = 2'd2
  } cfg_idx_e;

  // Kind of output run an item produces, fixed at its first byte.
  typedef enum logic [2:0] {
    K_ERR_LEN,
    K_ERR_DATA,
    K_HDR,
    K_HDR_CLOSE,
    K_DATA,
    K_DATA_CLOSE
  } kind_e;

  typedef enum logic [3:0] {
    SEL_SYNC_HI,
    SEL_SYNC_LO,
    SEL_CMD,
    SEL_LEN_HI,
    SEL_LEN_LO,
    SEL_DATA,
    SEL_CRC_HI,
    SEL_CRC_LO,
    SEL_TRL_HI,
    SEL_TRL_LO,
    SEL_ERR
  } sel_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } cfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       error_flag;
  } cfb_out_t;

  typedef struct packed {
    logic [15:0] crc_seed;
    logic [15:0] sync_word;
    logic [15:0] trailer_word;
  } cfb_cfg_t;

endpackage

### design/cfb_crc8.sv
module cfb_crc8 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import cfb_pkg::*;

  logic [15:0] c;

  // One byte through the CRC-CCITT register, MSB first.
  always_comb begin
    c = crc_i ^ {byte_i, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

### design/cfb_seq.sv
module cfb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cfb_pkg::cfb_in_t  item_i,
  input  cfb_pkg::cfb_cfg_t cfg_i,
  output cfb_pkg::cfb_out_t res_o
);
  import cfb_pkg::*;

  localparam logic [15:0]   MaxLen  = 16'(MaxPayload);
  localparam logic [RemW-1:0] RemOne = RemW'(1);

  logic [3:0]      pos_q, pos_d;
  kind_e           kind_q, kind_d, kind_c;
  logic [15:0]     crc_q, crc_d, crc_base, crc_next;
  logic [RemW-1:0] rem_q, rem_d;
  logic            open_q, open_d;
  sel_e            sel;
  logic            framed;
  logic            last;
  logic [7:0]      byte_val;

  // Classify the item against the frame state at its first byte.
  always_comb begin
    if (item_i.opcode == OP_HEADER) begin
      if (item_i.payload_length > MaxLen) begin
        kind_c = K_ERR_LEN;
      end else if (item_i.payload_length == 16'd0) begin
        kind_c = K_HDR_CLOSE;
      end else begin
        kind_c = K_HDR;
      end
    end else begin
      if (!open_q || rem_q == '0) begin
        kind_c = K_ERR_DATA;
      end else if (rem_q == RemOne) begin
        kind_c = K_DATA_CLOSE;
      end else begin
        kind_c = K_DATA;
      end
    end
  end

  assign kind_d = (pos_q == 4'd0) ? kind_c : kind_q;

  always_comb begin
    sel  = SEL_ERR;
    last = 1'b1;
    unique case (kind_d)
      K_ERR_LEN, K_ERR_DATA: begin
        sel  = SEL_ERR;
        last = 1'b1;
      end
      K_HDR, K_HDR_CLOSE: begin
        unique case (pos_q)
          4'd0:    sel = SEL_SYNC_HI;
          4'd1:    sel = SEL_SYNC_LO;
          4'd2:    sel = SEL_CMD;
          4'd3:    sel = SEL_LEN_HI;
          4'd4:    sel = SEL_LEN_LO;
          4'd5:    sel = SEL_CRC_HI;
          4'd6:    sel = SEL_CRC_LO;
          4'd7:    sel = SEL_TRL_HI;
          default: sel = SEL_TRL_LO;
        endcase
        last = (kind_d == K_HDR) ? (pos_q == 4'd4) : (pos_q == 4'd8);
      end
      K_DATA, K_DATA_CLOSE: begin
        unique case (pos_q)
          4'd0:    sel = SEL_DATA;
          4'd1:    sel = SEL_CRC_HI;
          4'd2:    sel = SEL_CRC_LO;
          4'd3:    sel = SEL_TRL_HI;
          default: sel = SEL_TRL_LO;
        endcase
        last = (kind_d == K_DATA) ? 1'b1 : (pos_q == 4'd4);
      end
      default: begin
        sel  = SEL_ERR;
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    framed   = 1'b0;
    byte_val = 8'h00;
    unique case (sel)
      SEL_SYNC_HI: begin framed = 1'b1; byte_val = cfg_i.sync_word[15:8]; end
      SEL_SYNC_LO: begin framed = 1'b1; byte_val = cfg_i.sync_word[7:0]; end
      SEL_CMD:     begin framed = 1'b1; byte_val = item_i.command; end
      SEL_LEN_HI:  begin framed = 1'b1; byte_val = item_i.payload_length[15:8]; end
      SEL_LEN_LO:  begin framed = 1'b1; byte_val = item_i.payload_length[7:0]; end
      SEL_DATA:    begin framed = 1'b1; byte_val = item_i.data_byte; end
      SEL_CRC_HI:  byte_val = crc_q[15:8];
      SEL_CRC_LO:  byte_val = crc_q[7:0];
      SEL_TRL_HI:  byte_val = cfg_i.trailer_word[15:8];
      SEL_TRL_LO:  byte_val = cfg_i.trailer_word[7:0];
      default:     byte_val = 8'h00;
    endcase
  end

  // Restart from the seed on the first sync byte of a frame.
  assign crc_base = (sel == SEL_SYNC_HI) ? cfg_i.crc_seed : crc_q;

  cfb_crc8 u_crc (
    .crc_i  (crc_base),
    .byte_i (byte_val),
    .crc_o  (crc_next)
  );

  assign res_o.out_byte    = byte_val;
  assign res_o.last_of_run = last;
  assign res_o.error_flag  = (sel == SEL_ERR);

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    rem_d  = rem_q;
    open_d = open_q;
    if (step_i) begin
      pos_d = last ? 4'd0 : pos_q + 4'd1;
      if (framed) begin
        crc_d = crc_next;
      end
      if (pos_q == 4'd0) begin
        unique case (kind_d)
          K_ERR_LEN, K_HDR_CLOSE, K_DATA_CLOSE: begin
            open_d = 1'b0;
            rem_d  = '0;
          end
          K_HDR: begin
            open_d = 1'b1;
            rem_d  = item_i.payload_length[RemW-1:0];
          end
          K_DATA: rem_d = rem_q - RemOne;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 4'd0;
      kind_q <= K_ERR_DATA;
      crc_q  <= 16'h0000;
      rem_q  <= '0;
      open_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      crc_q  <= crc_d;
      rem_q  <= rem_d;
      open_q <= open_d;
    end
  end

endmodule

### design/command_frame_builder_crc16.sv
// An accepted request is held in item_q; each result byte is registered in out_q before output.
// A payload or error request gives one output byte, the payload byte that ends a frame five,
// a header five, or nine with zero length; one byte goes out per cycle unless the output stalls.
// Reset: asynchronous, active low; clears frame state and the CRC register and
// loads seed 0xFFFF, sync 0xAA55 and trailer 0x55AA.
module command_frame_builder_crc16 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfb_pkg::cfb_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfb_pkg::cfb_out_t out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import cfb_pkg::*;

  cfb_cfg_t cfg_q;
  cfb_in_t  item_q;
  logic     item_valid_q;
  cfb_out_t out_q;
  logic     out_valid_q;
  cfb_out_t res;
  logic     out_adv;
  logic     step;
  logic     accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_seed     <= SeedReset;
      cfg_q.sync_word    <= SyncReset;
      cfg_q.trailer_word <= TrlReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRC_SEED: cfg_q.crc_seed     <= cfg_data_i;
        CFG_SYNC:     cfg_q.sync_word    <= cfg_data_i;
        CFG_TRAILER:  cfg_q.trailer_word <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && out_adv;
  // Take the next request while the last byte of this one moves out.
  assign in_ready_o = !item_valid_q || (out_adv && res.last_of_run);
  assign accept     = in_valid_i && in_ready_o;

  cfb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (step && res.last_of_run) begin
        item_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= step;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### design/cfb_checker.sv
`include "assert_macros.svh"

module cfb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cfb_pkg::cfb_out_t out_rsp_o
);

  `ASSERT_IMPL(a_err_is_single, clk_i, rst_ni, out_valid_o && out_rsp_o.error_flag,
               out_rsp_o.last_of_run && out_rsp_o.out_byte == 8'h00,
               "error result must be a lone zero byte")
  `ASSERT_NEXT(a_req_gives_result, clk_i, rst_ni, in_valid_i && in_ready_o,
               ##1 out_valid_o, "accepted request produced no result")
  `ASSERT_NEXT(a_run_continues, clk_i, rst_ni,
               out_valid_o && out_ready_i && !out_rsp_o.last_of_run,
               out_valid_o, "gap inside a result run")
  `ASSERT_NEXT(a_ready_while_out_free, clk_i, rst_ni, !out_valid_o && !in_ready_o,
               out_valid_o, "busy with empty output")
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(out_rsp_o), "stalled result changed")

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (.*);
